// ----- rtl/core/hre_pkg.sv -----
// Shared types, constants and helper functions of the hex record encoder.
package hre_pkg;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] MODE_S3   = 2'd0;
  localparam logic [1:0] MODE_IHEX = 2'd1;
  localparam logic [1:0] MODE_S2   = 2'd2;
  localparam logic [1:0] MODE_S1   = 2'd3;

  localparam logic [1:0] REG_FORMAT_MODE  = 2'd0;
  localparam logic [1:0] REG_LINE_SIZE    = 2'd1;
  localparam logic [1:0] REG_DEST_START   = 2'd2;
  localparam logic [1:0] REG_BLOCK_LENGTH = 2'd3;

  localparam logic [7:0] LINE_MAX     = 8'd250;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_S       = 8'h53;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] EXT_TYPE_SUM = 8'd6;

  typedef struct packed {
    logic [1:0]  format_mode;
    logic [7:0]  line_size;
    logic [31:0] dest_start;
    logic [31:0] block_length;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    format_mode:  MODE_S3,
    line_size:    8'd16,
    dest_start:   32'd0,
    block_length: 32'd1
  };

  typedef struct packed {
    logic        ext;
    logic [15:0] upper;
    logic [7:0]  ext_ck;
    logic        hdr;
    logic [7:0]  count;
    logic [31:0] addr;
    logic [7:0]  data;
    logic        trl;
    logic [7:0]  ck;
    logic        block_end;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'd0, nib};
    return (nib < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
  endfunction

  function automatic logic limit_hit(input logic [1:0] mode, input logic [31:0] a);
    logic hit;
    unique case (mode)
      MODE_S2: hit = |a[31:24];
      MODE_S1: hit = |a[31:16];
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ----- rtl/core/hre_in_if.sv -----
// Input channel carrying one data byte per beat.
interface hre_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source(output valid, output data_byte, input ready);
  modport sink(input valid, input data_byte, output ready);
endinterface

// ----- rtl/core/hre_out_if.sv -----
// Output channel carrying one record character per beat.
interface hre_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_of_run;
  logic       end_of_block;

  modport source(output valid, output char_code, output last_of_run, output end_of_block,
                 input ready);
  modport sink(input valid, input char_code, input last_of_run, input end_of_block,
               output ready);
endinterface

// ----- rtl/core/hre_cfg.sv -----
// APB register file holding the encoder configuration.
module hre_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hre_pkg::ADDR_W-1:0] paddr,
  input  logic [hre_pkg::DATA_W-1:0] pwdata,
  output logic [hre_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output hre_pkg::cfg_t              cfg,
  output hre_pkg::cfg_t              cfg_next,
  output logic                       restart
);
  import hre_pkg::*;

  logic [1:0] sel;
  logic       wr;

  assign sel     = paddr[ADDR_W-1:2];
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign restart = wr;

  always_comb begin
    cfg_next = cfg;
    if (rst) begin
      cfg_next = CFG_RESET;
    end else if (wr) begin
      unique case (sel)
        REG_FORMAT_MODE:  cfg_next.format_mode  = pwdata[1:0];
        REG_LINE_SIZE:    cfg_next.line_size    = pwdata[7:0];
        REG_DEST_START:   cfg_next.dest_start   = pwdata;
        REG_BLOCK_LENGTH: cfg_next.block_length = pwdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cfg <= cfg_next;
  end

  always_comb begin
    unique case (sel)
      REG_FORMAT_MODE:  prdata = {30'd0, cfg.format_mode};
      REG_LINE_SIZE:    prdata = {24'd0, cfg.line_size};
      REG_DEST_START:   prdata = cfg.dest_start;
      REG_BLOCK_LENGTH: prdata = cfg.block_length;
    endcase
  end

endmodule

// ----- rtl/core/hre_front.sv -----
// Block and line bookkeeping: turns each printed byte into one registered job.
module hre_front (
  input  logic          clk,
  input  logic          rst,
  input  hre_pkg::cfg_t cfg,
  input  hre_pkg::cfg_t cfg_next,
  input  logic          restart,
  input  logic          in_valid,
  input  logic [7:0]    in_data,
  output logic          in_ready,
  output logic          job_valid,
  output hre_pkg::job_t job,
  input  logic          job_ready
);
  import hre_pkg::*;

  logic [31:0] cur_addr, cur_addr_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [7:0]  line_pos, line_pos_next;
  logic [7:0]  line_len, line_len_next;
  logic [7:0]  run_sum, run_sum_next;
  logic [16:0] upper_seen, upper_seen_next;
  logic        past_limit, past_limit_next;
  logic        job_valid_next;
  job_t        job_next;

  logic        accept, active, line_start, limit_now, ihex;
  logic [7:0]  ls_eff, new_len, len, abytes, cnt, base, sum_pre, sum_new;
  logic [8:0]  pos_inc;
  logic        line_done;
  logic [31:0] addr_inc, bytes_dec;

  assign in_ready = !job_valid || job_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ihex       = (cfg.format_mode == MODE_IHEX);
    active     = (bytes_left != 32'd0) && !past_limit;
    line_start = (line_pos == 8'd0);
    limit_now  = line_start && limit_hit(cfg.format_mode, cur_addr);

    if (cfg.line_size == 8'd0) begin
      ls_eff = 8'd1;
    end else if (cfg.line_size > LINE_MAX) begin
      ls_eff = LINE_MAX;
    end else begin
      ls_eff = cfg.line_size;
    end
    new_len = ((bytes_left[31:8] == 24'd0) && (bytes_left[7:0] < ls_eff)) ?
              bytes_left[7:0] : ls_eff;
    len     = line_start ? new_len : line_len;

    unique case (cfg.format_mode)
      MODE_S3: abytes = 8'd4;
      MODE_S2: abytes = 8'd3;
      default: abytes = 8'd2;
    endcase
    cnt = ihex ? new_len : (new_len + abytes + 8'd1);

    base = cnt + cur_addr[7:0] + cur_addr[15:8];
    if (!ihex && (cfg.format_mode != MODE_S1)) begin
      base = base + cur_addr[23:16];
    end
    if (cfg.format_mode == MODE_S3) begin
      base = base + cur_addr[31:24];
    end

    sum_pre   = line_start ? base : run_sum;
    sum_new   = sum_pre + in_data;
    pos_inc   = {1'b0, line_pos} + 9'd1;
    line_done = pos_inc >= {1'b0, len};
    addr_inc  = cur_addr + 32'd1;
    bytes_dec = bytes_left - 32'd1;

    job_next.ext       = ihex && line_start && (upper_seen != {1'b0, cur_addr[31:16]});
    job_next.upper     = cur_addr[31:16];
    job_next.ext_ck    = 8'd0 - (EXT_TYPE_SUM + cur_addr[23:16] + cur_addr[31:24]);
    job_next.hdr       = line_start;
    job_next.count     = cnt;
    job_next.addr      = cur_addr;
    job_next.data      = in_data;
    job_next.trl       = line_done;
    job_next.ck        = ihex ? (8'd0 - sum_new) : ~sum_new;
    job_next.block_end = line_done &&
                         ((bytes_dec == 32'd0) || limit_hit(cfg.format_mode, addr_inc));

    cur_addr_next   = cur_addr;
    bytes_left_next = bytes_left;
    line_pos_next   = line_pos;
    line_len_next   = line_len;
    run_sum_next    = run_sum;
    upper_seen_next = upper_seen;
    past_limit_next = past_limit;
    job_valid_next  = job_valid && !job_ready;

    if (rst || restart) begin
      cur_addr_next   = cfg_next.dest_start;
      bytes_left_next = cfg_next.block_length;
      line_pos_next   = 8'd0;
      line_len_next   = 8'd0;
      run_sum_next    = 8'd0;
      upper_seen_next = 17'h10000;
      past_limit_next = 1'b0;
      job_valid_next  = 1'b0;
    end else if (accept && active) begin
      bytes_left_next = bytes_dec;
      if (limit_now) begin
        past_limit_next = 1'b1;
      end else begin
        job_valid_next = 1'b1;
        cur_addr_next  = addr_inc;
        line_len_next  = len;
        if (job_next.ext) begin
          upper_seen_next = {1'b0, cur_addr[31:16]};
        end
        if (line_done) begin
          line_pos_next = 8'd0;
          run_sum_next  = 8'd0;
        end else begin
          line_pos_next = pos_inc[7:0];
          run_sum_next  = sum_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_addr   <= cur_addr_next;
    bytes_left <= bytes_left_next;
    line_pos   <= line_pos_next;
    line_len   <= line_len_next;
    run_sum    <= run_sum_next;
    upper_seen <= upper_seen_next;
    past_limit <= past_limit_next;
    job_valid  <= job_valid_next;
    if (accept) begin
      job <= job_next;
    end
  end

endmodule

// ----- rtl/core/hre_serial.sv -----
// Character sequencer that prints one print job as record text, one character per beat.
module hre_serial (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    format_mode,
  input  logic          job_valid,
  input  hre_pkg::job_t job,
  output logic          job_ready,
  output logic          out_valid,
  output logic [7:0]    out_char,
  output logic          out_last,
  output logic          out_end,
  input  logic          out_ready
);
  import hre_pkg::*;

  localparam logic [1:0] SEG_EXT = 2'd0;
  localparam logic [1:0] SEG_HDR = 2'd1;
  localparam logic [1:0] SEG_DAT = 2'd2;
  localparam logic [1:0] SEG_TRL = 2'd3;

  logic       busy, busy_next;
  logic [1:0] seg, seg_next;
  logic [3:0] off, off_next;
  job_t       cur;
  logic       out_valid_next, out_last_next, out_end_next;
  logic [7:0] out_char_next;

  logic       adv, emit, seg_end, last, ihex, take;
  logic [3:0] hdr_len, nd;
  logic [2:0] nib_idx;
  logic [3:0] addr_nib;
  logic [7:0] ch;

  assign ihex = (format_mode == MODE_IHEX);

  always_comb begin
    unique case (format_mode)
      MODE_S3: nd = 4'd8;
      MODE_S2: nd = 4'd6;
      default: nd = 4'd4;
    endcase
    hdr_len  = ihex ? 4'd9 : (nd + 4'd4);
    nib_idx  = ihex ? 3'(4'd6 - off) : 3'(nd + 4'd3 - off);
    addr_nib = 4'(cur.addr >> {nib_idx, 2'b00});

    unique case (seg)
      SEG_EXT: begin
        unique case (off)
          4'd0:    ch = CHAR_COLON;
          4'd2:    ch = 8'h32;
          4'd8:    ch = 8'h34;
          4'd9:    ch = hex_char(cur.upper[15:12]);
          4'd10:   ch = hex_char(cur.upper[11:8]);
          4'd11:   ch = hex_char(cur.upper[7:4]);
          4'd12:   ch = hex_char(cur.upper[3:0]);
          4'd13:   ch = hex_char(cur.ext_ck[7:4]);
          4'd14:   ch = hex_char(cur.ext_ck[3:0]);
          4'd15:   ch = CHAR_NEWLINE;
          default: ch = CHAR_ZERO;
        endcase
      end
      SEG_HDR: begin
        if (off == 4'd0) begin
          ch = ihex ? CHAR_COLON : CHAR_S;
        end else if (!ihex && off == 4'd1) begin
          ch = (format_mode == MODE_S3) ? 8'h33 : ((format_mode == MODE_S2) ? 8'h32 : 8'h31);
        end else if (ihex && off <= 4'd2) begin
          ch = hex_char(off == 4'd1 ? cur.count[7:4] : cur.count[3:0]);
        end else if (!ihex && off <= 4'd3) begin
          ch = hex_char(off == 4'd2 ? cur.count[7:4] : cur.count[3:0]);
        end else if (ihex && off >= 4'd7) begin
          ch = CHAR_ZERO;
        end else begin
          ch = hex_char(addr_nib);
        end
      end
      SEG_DAT: ch = hex_char(off == 4'd0 ? cur.data[7:4] : cur.data[3:0]);
      SEG_TRL: begin
        unique case (off)
          4'd0:    ch = hex_char(cur.ck[7:4]);
          4'd1:    ch = hex_char(cur.ck[3:0]);
          default: ch = CHAR_NEWLINE;
        endcase
      end
    endcase

    unique case (seg)
      SEG_EXT: seg_end = (off == 4'd15);
      SEG_HDR: seg_end = (off == hdr_len - 4'd1);
      SEG_DAT: seg_end = (off == 4'd1);
      SEG_TRL: seg_end = (off == 4'd2);
    endcase
    last = seg_end && ((seg == SEG_TRL) || (seg == SEG_DAT && !cur.trl));

    adv       = !out_valid || out_ready;
    emit      = busy && adv;
    job_ready = !busy || (emit && last);
    take      = job_ready && job_valid;

    busy_next = busy;
    seg_next  = seg;
    off_next  = off;
    if (take) begin
      busy_next = 1'b1;
      off_next  = 4'd0;
      seg_next  = job.ext ? SEG_EXT : (job.hdr ? SEG_HDR : SEG_DAT);
    end else if (emit && last) begin
      busy_next = 1'b0;
    end else if (emit) begin
      if (seg_end) begin
        seg_next = seg + 2'd1;
        off_next = 4'd0;
      end else begin
        off_next = off + 4'd1;
      end
    end
    if (rst) begin
      busy_next = 1'b0;
      seg_next  = SEG_EXT;
      off_next  = 4'd0;
    end

    out_valid_next = out_valid;
    out_char_next  = out_char;
    out_last_next  = out_last;
    out_end_next   = out_end;
    if (adv) begin
      out_valid_next = busy;
      out_char_next  = ch;
      out_last_next  = last;
      out_end_next   = last && cur.block_end;
    end
    if (rst) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    busy      <= busy_next;
    seg       <= seg_next;
    off       <= off_next;
    out_valid <= out_valid_next;
    out_char  <= out_char_next;
    out_last  <= out_last_next;
    out_end   <= out_end_next;
    if (take) begin
      cur <= job;
    end
  end

endmodule

// ----- rtl/core/hex_record_encoder.sv -----
// Top level of the Intel HEX and Motorola S-record text encoder.
// Each accepted data byte becomes a run of 2 to 30 characters on the text channel, one character
// per cycle while the channel is ready: 2 for a byte inside a line, plus 8 to 12 for a record header
// on the first byte of a line, 3 for checksum and newline on its last byte, and 16 for an extended
// linear address record in Intel HEX mode. The character sequencer sets the rate; one further byte
// is buffered while a run prints, so runs follow each other without gaps. Bytes that cause no text
// are taken one per cycle while no print job waits. A register write restarts the block.
module hex_record_encoder (
  input  logic                       clk,
  input  logic                       rst,
  hre_in_if.sink                     data,
  hre_out_if.source                  text,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hre_pkg::ADDR_W-1:0] paddr,
  input  logic [hre_pkg::DATA_W-1:0] pwdata,
  output logic [hre_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import hre_pkg::*;

  cfg_t cfg, cfg_next;
  logic restart;
  logic job_valid, job_ready;
  job_t job;

  hre_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .cfg_next (cfg_next),
    .restart  (restart)
  );

  hre_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_next  (cfg_next),
    .restart   (restart),
    .in_valid  (data.valid),
    .in_data   (data.data_byte),
    .in_ready  (data.ready),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready)
  );

  hre_serial u_serial (
    .clk         (clk),
    .rst         (rst),
    .format_mode (cfg.format_mode),
    .job_valid   (job_valid),
    .job         (job),
    .job_ready   (job_ready),
    .out_valid   (text.valid),
    .out_char    (text.char_code),
    .out_last    (text.last_of_run),
    .out_end     (text.end_of_block),
    .out_ready   (text.ready)
  );

endmodule

// ----- tb/tb_hex_record_encoder.sv -----
// Self-checking testbench for hex_record_encoder: directed and random blocks with a built-in record predictor.
module tb_hex_record_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import hre_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_TICKS = 40;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       eob;
  } text_beat_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  hre_in_if  data_if ();
  hre_out_if text_if ();

  hex_record_encoder u_dut (
    .clk     (clk),
    .rst     (rst),
    .data    (data_if),
    .text    (text_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [7:0]  pending_bytes[$];
  text_beat_t  text_expect[$];
  logic [7:0]  run_chars[$];
  text_beat_t  want;
  int          fail_count;
  int          sent_bytes;
  int          send_idle_pct;
  int          stall_pct;
  logic        hold_req;
  logic        hold_seen;
  int          hold_cnt;

  cfg_t        enc_cfg;
  logic [31:0] cur_addr;
  logic [31:0] bytes_left;
  logic [7:0]  line_pos;
  logic [7:0]  line_len;
  logic [7:0]  run_sum;
  logic [16:0] upper_seen;
  logic        past_limit;

  function automatic logic over_limit(input logic [31:0] a);
    if (enc_cfg.format_mode == MODE_S2) return a >= 32'h0100_0000;
    if (enc_cfg.format_mode == MODE_S1) return a >= 32'h0001_0000;
    return 1'b0;
  endfunction

  function automatic void restart_block();
    cur_addr   = enc_cfg.dest_start;
    bytes_left = enc_cfg.block_length;
    line_pos   = '0;
    line_len   = '0;
    run_sum    = '0;
    upper_seen = 17'h1_0000;
    past_limit = 1'b0;
  endfunction

  function automatic void push_hex(input logic [31:0] value, input int digits);
    logic [3:0] nib;
    for (int d = digits - 1; d >= 0; d--) begin
      nib = value[4*d +: 4];
      run_chars.push_back(nib < 4'd10 ? CHAR_ZERO + 8'(nib) : 8'h41 + 8'(nib) - 8'd10);
    end
  endfunction

  function automatic void encode_byte(input logic [7:0] b);
    logic [7:0]  ls;
    logic [15:0] up;
    logic [7:0]  sum;
    logic [7:0]  cnt;
    int          abytes;
    logic        eob;
    string       ext_head;
    ext_head = ":02000004";
    eob = 1'b0;
    run_chars.delete();
    if (bytes_left == 0 || past_limit) return;
    if (line_pos == 0) begin
      if (over_limit(cur_addr)) begin
        past_limit = 1'b1;
        bytes_left--;
        return;
      end
      ls = enc_cfg.line_size;
      if (ls == 0) ls = 8'd1;
      if (ls > LINE_MAX) ls = LINE_MAX;
      line_len = (bytes_left < 32'(ls)) ? bytes_left[7:0] : ls;
      if (enc_cfg.format_mode == MODE_IHEX) begin
        up = cur_addr[31:16];
        if (upper_seen != {1'b0, up}) begin
          for (int i = 0; i < ext_head.len(); i++) run_chars.push_back(ext_head[i]);
          push_hex(32'(up), 4);
          sum = EXT_TYPE_SUM + up[7:0] + up[15:8];
          push_hex(32'(8'(8'd0 - sum)), 2);
          run_chars.push_back(CHAR_NEWLINE);
          upper_seen = {1'b0, up};
        end
        run_chars.push_back(CHAR_COLON);
        push_hex(32'(line_len), 2);
        push_hex(32'(cur_addr[15:0]), 4);
        push_hex(32'd0, 2);
        run_sum = line_len + cur_addr[7:0] + cur_addr[15:8];
      end else begin
        case (enc_cfg.format_mode)
          MODE_S3: abytes = 4;
          MODE_S2: abytes = 3;
          default: abytes = 2;
        endcase
        cnt = line_len + 8'(abytes) + 8'd1;
        run_chars.push_back(CHAR_S);
        case (enc_cfg.format_mode)
          MODE_S3: run_chars.push_back("3");
          MODE_S2: run_chars.push_back("2");
          default: run_chars.push_back("1");
        endcase
        push_hex(32'(cnt), 2);
        push_hex(cur_addr, abytes * 2);
        run_sum = cnt;
        for (int i = 0; i < abytes; i++) run_sum = run_sum + cur_addr[8*i +: 8];
      end
    end
    push_hex(32'(b), 2);
    run_sum = run_sum + b;
    line_pos++;
    cur_addr++;
    bytes_left--;
    if (line_pos >= line_len) begin
      push_hex(32'(enc_cfg.format_mode == MODE_IHEX ? 8'(8'd0 - run_sum) : ~run_sum), 2);
      run_chars.push_back(CHAR_NEWLINE);
      line_pos = '0;
      run_sum  = '0;
      eob = (bytes_left == 0) || over_limit(cur_addr);
    end
    foreach (run_chars[i]) begin
      text_expect.push_back('{ch: run_chars[i], last: i == run_chars.size() - 1,
                               eob: eob && (i == run_chars.size() - 1)});
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      data_if.valid <= 1'b0;
    end else begin
      if (data_if.valid && data_if.ready) encode_byte(data_if.data_byte);
      if (!data_if.valid || data_if.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          data_if.valid     <= 1'b1;
          data_if.data_byte <= pending_bytes.pop_front();
        end else begin
          data_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      text_if.ready <= 1'b0;
      hold_seen     <= 1'b0;
      hold_cnt      <= 0;
    end else begin
      if (text_if.valid && text_if.ready) begin
        if (text_expect.size() == 0) begin
          $error("char_code beat with nothing expected: got %h", text_if.char_code);
          fail_count++;
        end else begin
          want = text_expect.pop_front();
          if (text_if.char_code !== want.ch) begin
            $error("char_code mismatch: expected %h, got %h", want.ch, text_if.char_code);
            fail_count++;
          end
          if (text_if.last_of_run !== want.last) begin
            $error("last_of_run mismatch: expected %b, got %b", want.last, text_if.last_of_run);
            fail_count++;
          end
          if (text_if.end_of_block !== want.eob) begin
            $error("end_of_block mismatch: expected %b, got %b", want.eob,
                   text_if.end_of_block);
            fail_count++;
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen     <= hold_req;
        hold_cnt      <= HOLD_CYCLES;
        text_if.ready <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt      <= hold_cnt - 1;
        text_if.ready <= 1'b0;
      end else begin
        text_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || data_if.valid || text_expect.size() != 0);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FORMAT_MODE:  enc_cfg.format_mode  = value[1:0];
      REG_LINE_SIZE:    enc_cfg.line_size    = value[7:0];
      REG_DEST_START:   enc_cfg.dest_start   = value;
      REG_BLOCK_LENGTH: enc_cfg.block_length = value;
      default: ;
    endcase
    restart_block();
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic run_block(input cfg_t c, input int nbytes, input int idle, input int stall,
                           input int pause_at, input bit long_hold);
    wait_quiet();
    repeat (SETTLE_TICKS) @(negedge clk);
    send_idle_pct = idle;
    stall_pct     = stall;
    reg_write(REG_FORMAT_MODE, 32'(c.format_mode));
    reg_write(REG_LINE_SIZE, 32'(c.line_size));
    reg_write(REG_DEST_START, c.dest_start);
    reg_write(REG_BLOCK_LENGTH, c.block_length);
    if (long_hold) hold_req = ~hold_req;
    for (int i = 0; i < nbytes; i++) begin
      if (pause_at > 0 && i == pause_at) wait_quiet();
      pending_bytes.push_back(pick_byte());
      sent_bytes++;
    end
  endtask

  initial begin
    cfg_t        c;
    int          nbytes;
    int          phase;
    logic [31:0] near;
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    data_if.valid     = 1'b0;
    data_if.data_byte = '0;
    text_if.ready     = 1'b0;
    fail_count        = 0;
    sent_bytes        = 0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    hold_req          = 1'b0;
    enc_cfg           = CFG_RESET;
    restart_block();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: one-byte block, then a byte after the block is done.
    pending_bytes.push_back(8'hA5);
    pending_bytes.push_back(8'h3C);
    sent_bytes = sent_bytes + 2;
    // Intel HEX line running past a 64K boundary, then a new extended address.
    run_block(cfg_t'{MODE_IHEX, 8'd2, 32'h0000_FFFF, 32'd4}, 4, 0, 0, 0, 1'b0);
    // S1 with line size zero, stopped by the 16-bit address limit.
    run_block(cfg_t'{MODE_S1, 8'd0, 32'h0000_FFFE, 32'd5}, 5, 0, 0, 0, 1'b0);
    // S2 with oversize line size and a line that starts just under the limit.
    run_block(cfg_t'{MODE_S2, 8'd255, 32'h00FF_FFFE, 32'd3}, 3, 0, 0, 0, 1'b0);
    // S2 block that starts past the limit.
    run_block(cfg_t'{MODE_S2, 8'd250, 32'h0100_0000, 32'd2}, 2, 0, 0, 0, 1'b0);
    // S3 address wrap at the top of the address space.
    run_block(cfg_t'{MODE_S3, 8'd2, 32'hFFFF_FFFF, 32'd3}, 3, 0, 0, 0, 1'b0);
    // Zero block length.
    run_block(cfg_t'{MODE_S3, 8'd1, 32'h1234_5678, 32'd0}, 1, 0, 0, 0, 1'b0);
    // Longest block, left unfinished.
    run_block(cfg_t'{MODE_IHEX, 8'd250, 32'hFFFF_FFF0, 32'hFFFF_FFFF}, 2, 0, 0, 0, 1'b0);

    // Long receiver hold-off while bytes keep coming, then a mid-block sender pause.
    run_block(cfg_t'{MODE_IHEX, 8'd5, 32'h0001_FFF0, 32'd40}, 40, 0, 0, 0, 1'b1);
    run_block(cfg_t'{MODE_S3, 8'd4, 32'h8000_0000, 32'd30}, 30, 20, 20, 15, 1'b0);

    phase = 0;
    while (sent_bytes < 200) begin
      c.format_mode = 2'($urandom_range(3));
      c.line_size = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                              : 8'($urandom_range(1, 8));
      near = 32'($urandom_range(0, 6));
      case ($urandom_range(5))
        0: c.dest_start = $urandom();
        1: c.dest_start = 32'h0000_FFFF - near;
        2: c.dest_start = 32'h00FF_FFFF - near;
        3: c.dest_start = 32'hFFFF_FFFF - near;
        4: c.dest_start = 32'($urandom_range(32'hFFFF));
        default: c.dest_start = {16'($urandom_range(32'hFFFF)), 16'hFFFF - near[15:0]};
      endcase
      case ($urandom_range(15))
        0: begin
          c.block_length = 32'd0;
          nbytes = 1;
        end
        1, 2: begin
          c.block_length = $urandom();
          nbytes = $urandom_range(1, 24);
        end
        default: begin
          c.block_length = 32'($urandom_range(1, 24));
          nbytes = int'(c.block_length) + (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
        end
      endcase
      case (phase % 4)
        0: run_block(c, nbytes, 0, 0, 0, 1'b0);
        1: run_block(c, nbytes, 71, 0, 0, 1'b0);
        2: run_block(c, nbytes, 0, 71, 0, 1'b0);
        default: run_block(c, nbytes, 9, 9, 0, 1'b0);
      endcase
      phase++;
    end

    wait_quiet();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (fail_count == 0 && text_expect.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/hre_pkg.sv
rtl/core/hre_in_if.sv
rtl/core/hre_out_if.sv
rtl/core/hre_cfg.sv
rtl/core/hre_front.sv
rtl/core/hre_serial.sv
rtl/core/hex_record_encoder.sv
tb/tb_hex_record_encoder.sv
